[src/angle_gyro_kalman_filter_core_macros.svh]
// Assertion macros shared by the filter core.
`ifndef ANGLE_GYRO_KALMAN_FILTER_CORE_MACROS_SVH
`define ANGLE_GYRO_KALMAN_FILTER_CORE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define AGK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define AGK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/agk_pkg.sv]
// Shared types and constants of the angle and gyro Kalman filter core.
package agk_pkg;
  localparam int unsigned StAddrW = 3;
  localparam logic [StAddrW-1:0] ST_ANGLE = 3'd0;
  localparam logic [StAddrW-1:0] ST_BIAS = 3'd1;
  localparam logic [StAddrW-1:0] ST_AA = 3'd2;
  localparam logic [StAddrW-1:0] ST_AB = 3'd3;
  localparam logic [StAddrW-1:0] ST_BA = 3'd4;
  localparam logic [StAddrW-1:0] ST_BB = 3'd5;
  localparam int unsigned StDepth = 6;

  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_R = 2'd2;
  localparam logic [1:0] REG_DT = 2'd3;

  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;
  localparam logic signed [31:0] COV_ONE = 32'sd16777216;

  typedef struct packed {
    logic        start;
    logic [33:0] num_mag;
    logic        num_neg;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 66'(MAX32)) r = MAX32;
    if (v < 66'(MIN32)) r = MIN32;
    return r;
  endfunction

  function automatic logic signed [65:0] rnd24(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + 66'sd8388608;
    return t >>> 24;
  endfunction
endpackage

[src/agk_ram.sv]
// Generic single-port-write RAM with one registered read port.
module agk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[src/agk_div.sv]
// Restoring radix-2 divider for Q8.24 gains with rounding and saturation.
module agk_div (
  input  logic             clk,
  input  logic             rst_n,
  input  agk_pkg::div_req_t req,
  output agk_pkg::div_rsp_t rsp
);
  import agk_pkg::*;

  localparam int unsigned QW = 34;

  logic [QW+24-1:0] dvd_r, dvd_nxt;
  logic [33:0]      rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic             ovf_r;
  logic [32:0]      den_r;
  logic             neg_r;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, done_r;
  logic [34:0]      trial;
  logic [33:0]      shifted;
  logic [34:0]      qmag;
  logic signed [35:0] qs;

  always_comb begin
    shifted = {rem_r[32:0], dvd_r[QW+24-1]};
    trial = {1'b0, shifted} - {2'b0, den_r};
    rem_nxt = trial[34] ? shifted : trial[33:0];
    q_nxt = {q_r[QW-2:0], ~trial[34]};
    dvd_nxt = {dvd_r[QW+24-2:0], 1'b0};
    cnt_nxt = cnt_r - 6'd1;
    qmag = {1'b0, q_r};
    if (ovf_r || qmag > 35'd2147483648) qmag = 35'd2147483648;
    qs = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  // Dividend is (mag << 24) + den/2; quotient bits shifted out above bit 33 set the
  // overflow flag, which saturates the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dvd_r <= {req.num_mag[QW-1:0], 24'd0} + {26'd0, req.den[32:1]};
        den_r <= req.den;
        neg_r <= req.num_neg;
        rem_r <= '0;
        q_r <= '0;
        ovf_r <= 1'b0;
        cnt_r <= 6'(QW + 24);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r <= q_nxt;
        ovf_r <= ovf_r | q_r[QW-1];
        dvd_r <= dvd_nxt;
        cnt_r <= cnt_nxt;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = sat32(66'(qs));
endmodule

[src/angle_gyro_kalman_filter_core.sv]
// Top level: sequencer, shared multiplier, divider and state RAM of the filter.
// One item is processed at a time: the six state words live in a RAM read one word a
// cycle, ten products share one 33x33 multiplier with a register after it, and each of
// the two gains takes a 58-step radix-2 division, collected once the divider is done;
// both divisions are skipped when the divisor is not positive. A result waits in the
// output register; while that register still holds a result that is not taken, the last
// write-back cycle repeats, and the next item is taken once the state is written back
// and the result is loaded.
module angle_gyro_kalman_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // measured_angle[31:0], gyro_rate[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // angle_estimate_out[31:0], rate_estimate[63:32], fault[64]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import agk_pkg::*;
  `include "angle_gyro_kalman_filter_core_macros.svh"

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD, S_LD, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_DIV0, S_W0,
    S_DIV1, S_W1, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_WB, S_OUT
  } state_t;

  state_t state_r;
  logic [StAddrW-1:0] ptr_r;
  logic [StAddrW-1:0] rd_addr_r;
  logic [30:0] qa_r, qb_r, rn_r;
  logic [23:0] dt_r;
  logic signed [31:0] meas_r, gyro_r;
  logic signed [31:0] ang_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [31:0] rc_r, p00_r, p01_r, p10_r, p11_r, err_r, k0_r, k1_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] ma, mb;
  logic signed [65:0] rp;
  logic fault_r, out_valid_r;
  logic out_load;
  logic [71:0] out_data_r;
  logic ram_we;
  logic [StAddrW-1:0] ram_waddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic signed [33:0] e_sum;
  div_req_t dreq;
  div_rsp_t drsp;
  logic cfg_wr;

  agk_ram #(.Width(32), .Depth(StDepth)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(rd_addr_r), .rdata(ram_rdata)
  );

  agk_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (cfg_paddr[3:2])
      REG_QA: cfg_prdata = {1'b0, qa_r};
      REG_QB: cfg_prdata = {1'b0, qb_r};
      REG_R: cfg_prdata = {1'b0, rn_r};
      REG_DT: cfg_prdata = {8'd0, dt_r};
      default: cfg_prdata = '0;
    endcase
  end

  // Multiplier operand selection by step.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_P1: begin ma = 33'(rc_r); mb = 33'($signed({1'b0, dt_r})); end
      S_P2: begin
        ma = 33'(sat32(66'($signed({1'b0, qa_r})) - 66'(ab_r) - 66'(ba_r)));
        mb = 33'($signed({1'b0, dt_r}));
      end
      S_P3: begin ma = -33'(bb_r); mb = 33'($signed({1'b0, dt_r})); end
      S_P4: begin ma = 33'($signed({1'b0, qb_r})); mb = 33'($signed({1'b0, dt_r})); end
      S_C1: begin ma = 33'(k0_r); mb = 33'(p00_r); end
      S_C2: begin ma = 33'(k0_r); mb = 33'(p01_r); end
      S_C3: begin ma = 33'(k1_r); mb = 33'(p00_r); end
      S_C4: begin ma = 33'(k1_r); mb = 33'(p01_r); end
      S_C5: begin ma = 33'(k0_r); mb = 33'(err_r); end
      S_C6: begin ma = 33'(k1_r); mb = 33'(err_r); end
      default: ;
    endcase
  end

  assign rp = rnd24(prod_r);
  assign e_sum = 34'($signed({1'b0, rn_r})) + 34'(p00_r);

  always_comb begin
    dreq.start = 1'b0;
    dreq.num_neg = 1'b0;
    dreq.num_mag = '0;
    dreq.den = e_sum[32:0];
    if (state_r == S_DIV0 || state_r == S_DIV1) begin
      dreq.start = (e_sum > 34'sd0);
      if (state_r == S_DIV0) begin
        dreq.num_neg = p00_r[31];
        dreq.num_mag = p00_r[31] ? 34'(-34'(p00_r)) : 34'(p00_r);
      end else begin
        dreq.num_neg = p10_r[31];
        dreq.num_mag = p10_r[31] ? 34'(-34'(p10_r)) : 34'(p10_r);
      end
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    if (state_r == S_INIT) begin
      ram_we = 1'b1;
      ram_wdata = (ptr_r == ST_AA || ptr_r == ST_BB) ? COV_ONE : 32'sd0;
    end else if (state_r == S_WB) begin
      ram_we = 1'b1;
      case (ptr_r)
        ST_ANGLE: ram_wdata = ang_r;
        ST_BIAS: ram_wdata = bias_r;
        ST_AA: ram_wdata = aa_r;
        ST_AB: ram_wdata = ab_r;
        ST_BA: ram_wdata = ba_r;
        ST_BB: ram_wdata = bb_r;
        default: ram_wdata = '0;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_load = (state_r == S_WB) && (ptr_r == ST_BB) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ptr_r <= '0;
      rd_addr_r <= '0;
      out_valid_r <= 1'b0;
      qa_r <= 31'd16777;
      qb_r <= 31'd50332;
      rn_r <= 31'd11240735;
      dt_r <= 24'd83886;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_QA: qa_r <= cfg_pwdata[30:0];
          REG_QB: qb_r <= cfg_pwdata[30:0];
          REG_R: rn_r <= cfg_pwdata[30:0];
          REG_DT: dt_r <= cfg_pwdata[23:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      prod_r <= 66'(ma * mb);
      case (state_r)
        S_INIT: begin
          ptr_r <= ptr_r + 3'd1;
          if (ptr_r == 3'(StDepth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          meas_r <= in_tdata[31:0];
          gyro_r <= in_tdata[63:32];
          rd_addr_r <= ST_ANGLE;
          ptr_r <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          rd_addr_r <= rd_addr_r + 3'd1;
          state_r <= S_LD;
        end
        S_LD: begin
          case (ptr_r)
            ST_ANGLE: ang_r <= ram_rdata;
            ST_BIAS: bias_r <= ram_rdata;
            ST_AA: aa_r <= ram_rdata;
            ST_AB: ab_r <= ram_rdata;
            ST_BA: ba_r <= ram_rdata;
            ST_BB: bb_r <= ram_rdata;
            default: ;
          endcase
          ptr_r <= ptr_r + 3'd1;
          rd_addr_r <= rd_addr_r + 3'd1;
          if (ptr_r == ST_BB) state_r <= S_P1;
          else if (ptr_r == ST_BIAS)
            rc_r <= sat32(66'(gyro_r) - 66'($signed(ram_rdata)));
        end
        S_P1: state_r <= S_P2;
        S_P2: begin ang_r <= sat32(66'(ang_r) + rp); state_r <= S_P3; end
        S_P3: begin p00_r <= sat32(66'(aa_r) + rp); state_r <= S_P4; end
        S_P4: begin
          p01_r <= sat32(66'(ab_r) + rp);
          p10_r <= sat32(66'(ba_r) + rp);
          state_r <= S_P5;
        end
        S_P5: begin
          p11_r <= sat32(66'(bb_r) + rp);
          err_r <= sat32(66'(meas_r) - 66'(ang_r));
          state_r <= S_DIV0;
        end
        S_P6: state_r <= S_DIV0;
        S_DIV0: begin
          if (e_sum > 34'sd0) begin
            fault_r <= 1'b0;
            state_r <= S_W0;
          end else begin
            fault_r <= 1'b1;
            k0_r <= '0;
            k1_r <= '0;
            state_r <= S_C1;
          end
        end
        S_W0: if (drsp.done) begin k0_r <= drsp.quot; state_r <= S_DIV1; end
        S_DIV1: state_r <= S_W1;
        S_W1: if (drsp.done) begin k1_r <= drsp.quot; state_r <= S_C1; end
        S_C1: state_r <= S_C2;
        S_C2: begin aa_r <= sat32(66'(p00_r) - rp); state_r <= S_C3; end
        S_C3: begin ab_r <= sat32(66'(p01_r) - rp); state_r <= S_C4; end
        S_C4: begin ba_r <= sat32(66'(p10_r) - rp); state_r <= S_C5; end
        S_C5: begin bb_r <= sat32(66'(p11_r) - rp); state_r <= S_C6; end
        S_C6: begin
          ang_r <= sat32(66'(ang_r) + rp);
          state_r <= S_OUT;
        end
        S_OUT: begin
          bias_r <= sat32(66'(bias_r) + rp);
          ptr_r <= '0;
          state_r <= S_WB;
        end
        S_WB: begin
          if (ptr_r != ST_BB) begin
            ptr_r <= ptr_r + 3'd1;
          end else if (out_load) begin
            out_data_r <= {7'd0, fault_r, sat32(66'(gyro_r) - 66'(bias_r)), ang_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `AGK_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, !drsp.busy, "ready while divider busy")
  `AGK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `AGK_ASSERT_IMPL(a_div_start, clk, rst_n, dreq.start, !drsp.busy, "divider restarted")
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the angle and gyro Kalman filter core.
`timescale 1ns / 100ps

module tb_top;
  import agk_pkg::*;

  localparam int NumRandom = 750;
  localparam longint CycleLimit = 1500000;

  typedef struct packed {
    logic signed [31:0] gyro_rate;
    logic signed [31:0] measured_angle;
  } sample_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic               fault;
  } estimate_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  angle_gyro_kalman_filter_core dut (.*);

  // Predictor state and register copies.
  longint q_angle, q_bias, r_noise, dt_step;
  longint f_angle, f_bias, p_aa, p_ab, p_ba, p_bb;

  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        hold_off_req = 1'b0;
  int        hold_off_left;
  int        send_gap, recv_gap;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return (a * b + 64'sd8388608) >>> 24;
  endfunction

  function automatic longint divq(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag << 24) + den / 2) / den;
    if (q > 64'sd2147483648) q = 64'sd2147483648;
    return clamp32((num < 0) ? -q : q);
  endfunction

  function automatic void filter_reset();
    q_angle = 16777; q_bias = 50332; r_noise = 11240735; dt_step = 83886;
    f_angle = 0; f_bias = 0; p_aa = 16777216; p_ab = 0; p_ba = 0; p_bb = 16777216;
  endfunction

  function automatic estimate_t filter_step(sample_t s);
    longint meas, gyro, rc, err, e, k0, k1, p00, p01, p10, p11;
    estimate_t r;
    meas = longint'(s.measured_angle);
    gyro = longint'(s.gyro_rate);
    k0 = 0; k1 = 0;
    r.fault = 1'b0;
    rc = clamp32(gyro - f_bias);
    f_angle = clamp32(f_angle + mulq(rc, dt_step));
    p00 = clamp32(p_aa + mulq(clamp32(q_angle - p_ab - p_ba), dt_step));
    p01 = clamp32(p_ab + mulq(-p_bb, dt_step));
    p10 = clamp32(p_ba + mulq(-p_bb, dt_step));
    p11 = clamp32(p_bb + mulq(q_bias, dt_step));
    err = clamp32(meas - f_angle);
    e = r_noise + p00;
    if (e > 0) begin
      k0 = divq(p00, e);
      k1 = divq(p10, e);
    end else begin
      r.fault = 1'b1;
    end
    p_aa = clamp32(p00 - mulq(k0, p00));
    p_ab = clamp32(p01 - mulq(k0, p01));
    p_ba = clamp32(p10 - mulq(k1, p00));
    p_bb = clamp32(p11 - mulq(k1, p01));
    f_angle = clamp32(f_angle + mulq(k0, err));
    f_bias = clamp32(f_bias + mulq(k1, err));
    r.angle = f_angle[31:0];
    r.rate = 32'(clamp32(gyro - f_bias));
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Input driver: predicts on each accepted transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_estimates.push_back(filter_step(sample_t'(in_tdata)));
        void'(pending_samples.pop_front());
        send_gap <= $urandom_range(0, 7);
        in_tvalid <= 1'b0;
      end else if (!in_tvalid && pending_samples.size() > 0) begin
        if (send_gap == 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_samples[0];
        end else begin
          send_gap <= send_gap - 1;
        end
      end
    end
  end

  // Output monitor with random stalls and one long hold-off.
  always @(posedge clk) begin
    estimate_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
      hold_off_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.angle = out_tdata[31:0];
        got.rate = out_tdata[63:32];
        got.fault = out_tdata[64];
        if (expected_estimates.size() == 0) begin
          $display("%0t: unexpected transfer %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_estimates.pop_front();
          if (got.angle !== want.angle) begin
            $display("%0t: angle exp %h got %h", $time, want.angle, got.angle);
            errors++;
          end
          if (got.rate !== want.rate) begin
            $display("%0t: rate exp %h got %h", $time, want.rate, got.rate);
            errors++;
          end
          if (got.fault !== want.fault) begin
            $display("%0t: fault exp %b got %b", $time, want.fault, got.fault);
            errors++;
          end
        end
      end
      if (hold_off_req && hold_off_left == 0) begin
        hold_off_left <= 2000;
        hold_off_req <= 1'b0;
        out_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_tready <= (hold_off_left == 1);
      end else if (out_tvalid && out_tready) begin
        recv_gap = $urandom_range(0, 7);
        out_tready <= (recv_gap == 0);
      end else if (!out_tready) begin
        if (recv_gap > 0) recv_gap = recv_gap - 1;
        out_tready <= (recv_gap == 0);
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, longint value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value[31:0];
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_QA: q_angle = value & 64'h7fffffff;
      REG_QB: q_bias = value & 64'h7fffffff;
      REG_R: r_noise = value & 64'h7fffffff;
      default: dt_step = value & 64'hffffff;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || expected_estimates.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  task automatic push_random(int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.measured_angle = rand_word();
      s.gyro_rate = rand_word();
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    sample_t s;
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    filter_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and saturation with reset settings.
    s = '{32'sh7fffffff, 32'sh7fffffff}; pending_samples.push_back(s);
    s = '{32'sh80000000, 32'sh80000000}; pending_samples.push_back(s);
    s = '{32'sh80000000, 32'sh7fffffff}; pending_samples.push_back(s);
    s = '{32'sh7fffffff, 32'sh80000000}; pending_samples.push_back(s);
    s = '{32'h0, 32'h0}; pending_samples.push_back(s);
    s = '{32'hffffffff, 32'h55555555}; pending_samples.push_back(s);
    s = '{32'haaaaaaaa, 32'hffffffff}; pending_samples.push_back(s);
    drain();

    // Extremes of the registers: first all at their maximum, then zero with a noise of one.
    cfg_write(REG_QA, 64'h7fffffff);
    cfg_write(REG_QB, 64'h7fffffff);
    cfg_write(REG_R, 64'h7fffffff);
    cfg_write(REG_DT, 64'hffffff);
    push_random(8);
    drain();
    cfg_write(REG_QA, 0);
    cfg_write(REG_QB, 0);
    cfg_write(REG_R, 1);
    cfg_write(REG_DT, 0);
    push_random(6);
    drain();

    // Random phases; the first includes a long receiver hold-off.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        cfg_write(REG_QA, 16777); cfg_write(REG_QB, 50332);
        cfg_write(REG_R, 11240735); cfg_write(REG_DT, 83886);
      end else begin
        cfg_write(REG_QA, $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 30));
        cfg_write(REG_QB, $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 30));
        cfg_write(REG_R, 1 + ($urandom_range(0, 32'h7ffffffe) >> $urandom_range(0, 30)));
        cfg_write(REG_DT, $urandom_range(0, 24'hffffff) >> $urandom_range(0, 23));
      end
      push_random(NumRandom / 5);
      if (ph == 0) hold_off_req = 1'b1;
      drain();
    end

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
